// File: hdl/pts_pkg.sv
package pts_pkg;

  // Entity ids address the sparse map directly.
  localparam int ENT_W       = 10;
  localparam int ENTITY_SPAN = 1 << ENT_W;

  // Dense table geometry.
  localparam int MAX_ENTRIES = 1024;
  localparam int SLOT_W      = $clog2(MAX_ENTRIES);
  localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
  localparam int DATA_W      = 32;

  // Fixed field widths of the channels.
  localparam int REQ_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 11;

  localparam logic [REQ_W-1:0] REQ_ADD     = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_GET     = 2'd2;
  localparam logic [REQ_W-1:0] REQ_DESTROY = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  // One word of the sparse map: presence mark and dense slot.
  typedef struct packed {
    logic              present;
    logic [SLOT_W-1:0] slot;
  } sparse_word_t;

  // Write request into the sparse map.
  typedef struct packed {
    logic             en;
    logic [ENT_W-1:0] addr;
    sparse_word_t     word;
  } sparse_wr_t;

  // One word of the dense table: owning entity and its data.
  typedef struct packed {
    logic [ENT_W-1:0]  owner;
    logic [DATA_W-1:0] data;
  } dense_word_t;

endpackage

// File: hdl/pts_req_if.sv
interface pts_req_if;
  logic                         valid;
  logic                         ready;
  logic [pts_pkg::REQ_W-1:0]    req_type;
  logic [pts_pkg::ENT_W-1:0]    entity_id;
  logic [pts_pkg::VALUE_W-1:0]  item_value;

  modport source (output valid, output req_type, output entity_id, output item_value,
                  input ready);
  modport sink (input valid, input req_type, input entity_id, input item_value,
                output ready);
endinterface

// File: hdl/pts_rsp_if.sv
interface pts_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pts_pkg::STATUS_W-1:0]  status;
  logic [pts_pkg::VALUE_W-1:0]   read_value;
  logic [pts_pkg::FILL_W-1:0]    fill_count;

  modport source (output valid, output status, output read_value, output fill_count,
                  input ready);
  modport sink (input valid, input status, input read_value, input fill_count,
                output ready);
endinterface

// File: hdl/packed_table_swap_remove.sv
// Packed table with swap-remove, keyed by a 10-bit entity id.
// Requests arrive on in_req (add, remove, get, destroy) and each one gives
// exactly one item on out_rsp carrying status, read data and fill count.
// Items move with valid/ready and are taken when both are high.
// One request is in work at a time. Add and any request that misses finish in
// the lookup state; a get that hits then reads the dense slot that the map
// points to, and a remove or destroy that moves a slot then writes the sparse
// map a second time to clear the removed entity. The steps follow from the
// dependent accesses to the two single-port memories.
// Results go to an output register backed by one holding register, so a
// stalled receiver holds at most two results; once both are full, in_req.ready
// stays low until out_rsp.ready drains them.
// After rst_n is released the sparse map is cleared one entry per cycle, and
// in_req.ready stays low during that pass. The fill count is zero after reset
// and the dense table is left as it was, since a slot is only read once it
// has been written.
module packed_table_swap_remove (
  input  logic            clk,
  input  logic            rst_n,
  pts_req_if.sink         in_req,
  pts_rsp_if.source       out_rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_GET  = 2'd2;
  localparam logic [1:0] S_WR2  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [pts_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [pts_pkg::COUNT_W-1:0] cnt_m1;

  // Request held while it is in work.
  logic [pts_pkg::REQ_W-1:0]  req_r;
  logic [pts_pkg::ENT_W-1:0]  ent_r;
  logic [pts_pkg::DATA_W-1:0] val_r;

  logic in_ready;
  logic in_acc;

  // Sparse map access.
  logic                      sp_rd_en;
  logic [pts_pkg::ENT_W-1:0] sp_rd_addr;
  pts_pkg::sparse_word_t     sp_rd;
  pts_pkg::sparse_wr_t       sp_wr;
  logic                      sp_busy;

  // Dense table: owner and data per slot.
  pts_pkg::dense_word_t       dense_mem [pts_pkg::MAX_ENTRIES];
  pts_pkg::dense_word_t       dn_rd_r;
  logic                       dn_rd_en;
  logic [pts_pkg::SLOT_W-1:0] dn_rd_addr;
  logic                       dn_wr_en;
  logic [pts_pkg::SLOT_W-1:0] dn_wr_addr;
  pts_pkg::dense_word_t       dn_wr_data;

  // Result path.
  logic                         res_vld;
  logic [pts_pkg::STATUS_W-1:0] res_status;
  logic [pts_pkg::VALUE_W-1:0]  res_value;
  logic                         out_vld_r;
  logic [pts_pkg::STATUS_W-1:0] out_status_r;
  logic [pts_pkg::VALUE_W-1:0]  out_value_r;
  logic [pts_pkg::FILL_W-1:0]   out_fill_r;
  logic                         pend_vld_r;
  logic [pts_pkg::STATUS_W-1:0] pend_status_r;
  logic [pts_pkg::VALUE_W-1:0]  pend_value_r;
  logic [pts_pkg::FILL_W-1:0]   pend_fill_r;
  logic                         out_free;
  logic [pts_pkg::FILL_W-1:0]   res_fill;

  pts_sparse_mem u_sparse (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (sp_rd_en),
    .rd_addr (sp_rd_addr),
    .rd_data (sp_rd),
    .wr      (sp_wr),
    .busy    (sp_busy)
  );

  // A new request is taken only when idle, the map is cleared and there is
  // room for its result even if the receiver keeps stalling.
  assign in_ready     = (state_r == S_IDLE) && !sp_busy && !pend_vld_r;
  assign in_acc       = in_req.valid && in_ready;
  assign in_req.ready = in_ready;
  assign cnt_m1       = count_r - pts_pkg::COUNT_W'(1);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    sp_rd_en   = 1'b0;
    sp_rd_addr = in_req.entity_id;
    sp_wr      = '0;
    dn_rd_en   = 1'b0;
    dn_rd_addr = cnt_m1[pts_pkg::SLOT_W-1:0];
    dn_wr_en   = 1'b0;
    dn_wr_addr = count_r[pts_pkg::SLOT_W-1:0];
    dn_wr_data = '0;
    res_vld    = 1'b0;
    res_status = pts_pkg::ST_OK;
    res_value  = '0;
    case (state_r)
      S_IDLE: begin
        // Look up the entity and, in parallel, the last occupied slot.
        if (in_acc) begin
          sp_rd_en  = 1'b1;
          dn_rd_en  = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        case (req_r)
          pts_pkg::REQ_ADD: begin
            res_vld   = 1'b1;
            state_nxt = S_IDLE;
            if (sp_rd.present) begin
              res_status = pts_pkg::ST_DUP;
            end else if (count_r == pts_pkg::COUNT_W'(pts_pkg::MAX_ENTRIES)) begin
              res_status = pts_pkg::ST_FULL;
            end else begin
              // Append at the end of the dense table.
              sp_wr.en           = 1'b1;
              sp_wr.addr         = ent_r;
              sp_wr.word.present = 1'b1;
              sp_wr.word.slot    = count_r[pts_pkg::SLOT_W-1:0];
              dn_wr_en           = 1'b1;
              dn_wr_data.owner   = ent_r;
              dn_wr_data.data    = val_r;
              count_nxt          = count_r + pts_pkg::COUNT_W'(1);
            end
          end
          pts_pkg::REQ_GET: begin
            if (sp_rd.present) begin
              dn_rd_en   = 1'b1;
              dn_rd_addr = sp_rd.slot;
              state_nxt  = S_GET;
            end else begin
              res_vld    = 1'b1;
              res_status = pts_pkg::ST_NOTFOUND;
              state_nxt  = S_IDLE;
            end
          end
          default: begin
            // Remove and destroy: move the last slot into the hole.
            if (sp_rd.present && (count_r != '0)) begin
              dn_wr_en           = 1'b1;
              dn_wr_addr         = sp_rd.slot;
              dn_wr_data         = dn_rd_r;
              sp_wr.en           = 1'b1;
              sp_wr.addr         = dn_rd_r.owner;
              sp_wr.word.present = 1'b1;
              sp_wr.word.slot    = sp_rd.slot;
              count_nxt          = cnt_m1;
              state_nxt          = S_WR2;
            end else begin
              res_vld    = 1'b1;
              res_status = (req_r == pts_pkg::REQ_REMOVE) ? pts_pkg::ST_NOTFOUND
                                                          : pts_pkg::ST_OK;
              state_nxt  = S_IDLE;
            end
          end
        endcase
      end
      S_GET: begin
        res_vld   = 1'b1;
        res_value = pts_pkg::VALUE_W'(dn_rd_r.data);
        state_nxt = S_IDLE;
      end
      S_WR2: begin
        // Clear the removed entity last, so a self-move ends absent.
        sp_wr.en           = 1'b1;
        sp_wr.addr         = ent_r;
        sp_wr.word.present = 1'b0;
        sp_wr.word.slot    = '0;
        res_vld            = 1'b1;
        state_nxt          = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res_fill = pts_pkg::FILL_W'(count_nxt);
  assign out_free = !out_vld_r || out_rsp.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= in_req.req_type;
      ent_r <= in_req.entity_id;
      val_r <= in_req.item_value[pts_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (dn_wr_en) begin
      dense_mem[dn_wr_addr] <= dn_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (dn_rd_en) begin
      dn_rd_r <= dense_mem[dn_rd_addr];
    end
  end

  // Output register with one holding register behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else if (res_vld) begin
      if (out_free) begin
        out_vld_r <= 1'b1;
      end else begin
        pend_vld_r <= 1'b1;
      end
    end else if (pend_vld_r && out_free) begin
      out_vld_r  <= 1'b1;
      pend_vld_r <= 1'b0;
    end else if (out_rsp.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      if (out_free) begin
        out_status_r <= res_status;
        out_value_r  <= res_value;
        out_fill_r   <= res_fill;
      end else begin
        pend_status_r <= res_status;
        pend_value_r  <= res_value;
        pend_fill_r   <= res_fill;
      end
    end else if (pend_vld_r && out_free) begin
      out_status_r <= pend_status_r;
      out_value_r  <= pend_value_r;
      out_fill_r   <= pend_fill_r;
    end
  end

  assign out_rsp.valid      = out_vld_r;
  assign out_rsp.status     = out_status_r;
  assign out_rsp.read_value = out_value_r;
  assign out_rsp.fill_count = out_fill_r;

  // The lookup state is entered only from an accepted request.
  a_look_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && state_r == S_LOOK) |-> $past(in_acc))
    else $error("lookup without an accepted request");

  // The second write of a swap-remove directly follows the lookup.
  a_wr2_after_look: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && state_r == S_WR2) |-> ($past(state_r) == S_LOOK))
    else $error("second map write out of sequence");

  // The fill count moves only as a result of a lookup.
  a_count_moves_in_look: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && count_r != $past(count_r)) |-> ($past(state_r) == S_LOOK))
    else $error("fill count changed outside a lookup");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= pts_pkg::COUNT_W'(pts_pkg::MAX_ENTRIES))
    else $error("fill count beyond table size");

  // A held result always sits behind a shown one.
  a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> out_vld_r)
    else $error("held result with empty output register");

  // No map update may collide with the clearing pass.
  a_no_write_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    sp_busy |-> !sp_wr.en)
    else $error("map write during clearing pass");

endmodule

// File: hdl/pts_sparse_mem.sv
// Sparse map from entity to slot. After reset a clearing pass writes every
// entry as absent, one per cycle, and busy stays high until it is done.
module pts_sparse_mem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [pts_pkg::ENT_W-1:0] rd_addr,
  output pts_pkg::sparse_word_t     rd_data,
  input  pts_pkg::sparse_wr_t       wr,
  output logic                      busy
);

  pts_pkg::sparse_word_t     mem [pts_pkg::ENTITY_SPAN];
  pts_pkg::sparse_word_t     rd_data_r;
  logic                      clr_active_r;
  logic [pts_pkg::ENT_W-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + pts_pkg::ENT_W'(1);
      if (clr_addr_r == pts_pkg::ENT_W'(pts_pkg::ENTITY_SPAN - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.word;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_active_r;

endmodule
